// ===== hdl/ela_pkg.sv =====
// shared constants, codes and types of the event latency accumulator
package ela_pkg;

  localparam int unsigned PID_BITS_DEF    = 15;
  localparam int unsigned ACC_ENTRIES_DEF = 256;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned CALL_W          = 10;
  localparam int unsigned TS_W            = 64;
  localparam int unsigned SEL_W           = 8;
  localparam int unsigned STATUS_W        = 4;
  localparam int unsigned COUNT_W         = 32;
  localparam int unsigned MAX_W           = 32;
  localparam int unsigned LIMIT_W         = 40;
  localparam int unsigned APB_DW          = 64;
  localparam int unsigned APB_AW          = 4;

  localparam logic [LIMIT_W-1:0] STALE_RESET = 40'd30000000000;
  localparam logic [TS_W-1:0]    CLAMP32     = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED  = 4'd0,
    ST_PID0    = 4'd1,
    ST_NOSTART = 4'd2,
    ST_STALE   = 4'd3,
    ST_UPDATED = 4'd4,
    ST_NEW     = 4'd5,
    ST_FULL    = 4'd6,
    ST_READ    = 4'd7,
    ST_EMPTY   = 4'd8
  } status_e;

  // accumulator contents of one slot
  typedef struct packed {
    logic [TS_W-1:0]    total;
    logic [COUNT_W-1:0] count;
    logic [MAX_W-1:0]   maxv;
  } acc_t;

  // start table entry
  typedef struct packed {
    logic            vld;
    logic [TS_W-1:0] ts;
  } start_t;

endpackage

// ===== hdl/ela_if.sv =====
// item channels of the event latency accumulator
interface ela_in_if import ela_pkg::*; #(
  parameter int unsigned PID_BITS = PID_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [PID_BITS-1:0] pid;
  logic [CALL_W-1:0]   call_number;
  logic [TS_W-1:0]     timestamp_ns;
  logic [SEL_W-1:0]    slot_select;

  modport source (output valid, op, pid, call_number, timestamp_ns, slot_select,
                  input ready);
  modport sink (input valid, op, pid, call_number, timestamp_ns, slot_select,
                output ready);
endinterface

interface ela_out_if import ela_pkg::*; #(
  parameter int unsigned PID_BITS = PID_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SEL_W-1:0]    slot;
  logic [PID_BITS-1:0] key_pid;
  logic [CALL_W-1:0]   key_call;
  logic [TS_W-1:0]     delta_ns;
  logic [TS_W-1:0]     sum_ns;
  logic [COUNT_W-1:0]  event_count;
  logic [MAX_W-1:0]    max_ns;

  modport source (output valid, status, slot, key_pid, key_call, delta_ns, sum_ns,
                  event_count, max_ns, input ready);
  modport sink (input valid, status, slot, key_pid, key_call, delta_ns, sum_ns,
                event_count, max_ns, output ready);
endinterface

// ===== hdl/ela_smem.sv =====
// start timestamp memory, one entry per pid, registered read
module ela_smem import ela_pkg::*; #(
  parameter int unsigned PID_BITS = PID_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [PID_BITS-1:0] rd_addr_i,
  output start_t              rd_data_o,
  input  logic                wr_en_i,
  input  logic [PID_BITS-1:0] wr_addr_i,
  input  start_t              wr_data_i
);

  start_t mem [2**PID_BITS];
  start_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== hdl/ela_cell.sv =====
// one accumulator slot: key, running sums and key compare
module ela_cell import ela_pkg::*; #(
  parameter int unsigned KEY_W = PID_BITS_DEF + CALL_W
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [KEY_W-1:0] wr_key_i,
  input  acc_t             wr_acc_i,
  input  logic             used_i,
  input  logic [KEY_W-1:0] look_key_i,
  output logic             hit_o,
  output logic [KEY_W-1:0] key_o,
  output acc_t             acc_o
);

  logic [KEY_W-1:0] key_q;
  acc_t             acc_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_q <= wr_key_i;
      acc_q <= wr_acc_i;
    end
  end

  assign hit_o = used_i && (key_q == look_key_i);
  assign key_o = key_q;
  assign acc_o = acc_q;

endmodule

// ===== hdl/event_latency_accumulator.sv =====
// event latency accumulator: one item at a time, so a new item is taken only after the
// last one has finished its look, select and done steps; the result waits in an output
// register and the last step stalls only if that register is still full.
// the pace is set by the registered start-memory read, the slot compare across the row
// of cells and the select-out of the matching cell ahead of its read-modify-write.
// after reset a clearing pass over all 2**PID_BITS entries (32768 at default) empties the
// start table before the first item is taken; configuration writes are taken throughout.
module event_latency_accumulator import ela_pkg::*; #(
  parameter int unsigned PID_BITS    = PID_BITS_DEF,
  parameter int unsigned ACC_ENTRIES = ACC_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ela_in_if.sink            in_if,
  ela_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned KEY_W  = PID_BITS + CALL_W;
  localparam int unsigned SLOT_W = $clog2(ACC_ENTRIES);
  localparam int unsigned USED_W = SLOT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SEL  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration register, decoded at addresses 0 to 7 (top address bit low)
  logic [LIMIT_W-1:0] limit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= STALE_RESET;
    end else if (psel && penable && pwrite && !paddr[APB_AW-1]) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = paddr[APB_AW-1] ? '0 : APB_DW'(limit_q);

  // start table clearing pass after reset
  logic                clr_busy_q;
  logic [PID_BITS-1:0] clr_addr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  logic accept;
  assign in_if.ready = (state_q == S_IDLE) && !clr_busy_q;
  assign accept      = in_if.valid && in_if.ready;

  // item registers
  op_e                 op_q;
  logic [PID_BITS-1:0] pid_q;
  logic [CALL_W-1:0]   call_q;
  logic [TS_W-1:0]     ts_q;
  logic [SEL_W-1:0]    sel_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(in_if.op);
      pid_q  <= in_if.pid;
      call_q <= in_if.call_number;
      ts_q   <= in_if.timestamp_ns;
      sel_q  <= in_if.slot_select;
    end
  end

  logic             pid0;
  logic [KEY_W-1:0] item_key;
  assign pid0     = (pid_q == '0);
  assign item_key = {pid_q, call_q};

  // start memory: read on accept, written in the look step or by the clearing pass
  start_t              start_rd, look_wr, mem_wr;
  logic                look_we, mem_we;
  logic [PID_BITS-1:0] mem_waddr;

  always_comb begin
    look_wr.vld = (op_q == OP_ENTER);
    look_wr.ts  = ts_q;
    look_we     = (state_q == S_LOOK) && !pid0 &&
                  ((op_q == OP_ENTER) || ((op_q == OP_EXIT) && start_rd.vld));
    mem_we      = clr_busy_q || look_we;
    mem_waddr   = clr_busy_q ? clr_addr_q : pid_q;
    mem_wr      = clr_busy_q ? '0 : look_wr;
  end

  ela_smem #(.PID_BITS(PID_BITS)) u_smem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (in_if.pid),
    .rd_data_o (start_rd),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wr)
  );

  // latency of the exit and the stale check
  logic [TS_W-1:0] delta_d, delta_q;
  logic            svld_q, stale_q, stale_d;
  assign delta_d = ts_q - start_rd.ts;
  assign stale_d = (delta_d[TS_W-1:LIMIT_W] != '0) || (delta_d[LIMIT_W-1:0] > limit_q);

  // row of slot cells
  logic [USED_W-1:0]      used_q;
  logic [ACC_ENTRIES-1:0] cell_hit, cell_we, hot_d, hot_q;
  logic [KEY_W-1:0]       cell_key [ACC_ENTRIES];
  acc_t                   cell_acc [ACC_ENTRIES];
  logic                   acc_we;
  logic                   finish;
  logic [SLOT_W-1:0]      acc_widx;
  logic [KEY_W-1:0]       wr_key;
  acc_t                   wr_acc;

  for (genvar i = 0; i < ACC_ENTRIES; i++) begin : g_cell
    logic used;
    assign used       = (USED_W'(i) < used_q);
    // a cell is written only by the finishing step of its item
    assign cell_we[i] = finish && acc_we && (acc_widx == SLOT_W'(i));
    assign hot_d[i]   = (op_q == OP_READ) ? (used && (int'(sel_q) == i)) : cell_hit[i];

    ela_cell #(.KEY_W(KEY_W)) u_cell (
      .clk_i      (clk_i),
      .we_i       (cell_we[i]),
      .wr_key_i   (wr_key),
      .wr_acc_i   (wr_acc),
      .used_i     (used),
      .look_key_i (item_key),
      .hit_o      (cell_hit[i]),
      .key_o      (cell_key[i]),
      .acc_o      (cell_acc[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOOK) begin
      delta_q <= delta_d;
      svld_q  <= start_rd.vld;
      stale_q <= stale_d;
      hot_q   <= hot_d;
    end
  end

  // select-out of the one hot cell (keys are unique, so at most one hits)
  logic              any_d, any_q;
  logic [KEY_W-1:0]  selkey_d, selkey_q;
  logic [SLOT_W-1:0] selidx_d, selidx_q;
  acc_t              selacc_d, selacc_q;

  always_comb begin
    any_d    = 1'b0;
    selkey_d = '0;
    selidx_d = '0;
    selacc_d = '0;
    for (int i = 0; i < ACC_ENTRIES; i++) begin
      if (hot_q[i]) begin
        any_d    = 1'b1;
        selkey_d = selkey_d | cell_key[i];
        selidx_d = selidx_d | SLOT_W'(i);
        selacc_d = selacc_d | cell_acc[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SEL) begin
      any_q    <= any_d;
      selkey_q <= selkey_d;
      selidx_q <= selidx_d;
      selacc_q <= selacc_d;
    end
  end

  // result forming and slot write-back
  logic [MAX_W-1:0]    d32;
  logic                full;
  logic                emit, out_free;
  status_e             res_status;
  logic [SEL_W-1:0]    res_slot;
  logic [PID_BITS-1:0] res_pid;
  logic [CALL_W-1:0]   res_call;
  logic [TS_W-1:0]     res_delta;
  acc_t                res_acc, upd_acc;
  logic                new_slot;

  assign d32  = (delta_q > CLAMP32) ? '1 : delta_q[MAX_W-1:0];
  assign full = (used_q == USED_W'(ACC_ENTRIES));

  always_comb begin
    upd_acc.total = selacc_q.total + delta_q;
    upd_acc.count = selacc_q.count + 1'b1;
    upd_acc.maxv  = (d32 > selacc_q.maxv) ? d32 : selacc_q.maxv;
  end

  always_comb begin
    emit       = 1'b1;
    res_status = ST_EMPTY;
    res_slot   = '0;
    res_pid    = '0;
    res_call   = '0;
    res_delta  = '0;
    res_acc    = '0;
    acc_we     = 1'b0;
    acc_widx   = selidx_q;
    wr_key     = item_key;
    wr_acc     = upd_acc;
    new_slot   = 1'b0;
    case (op_q)
      OP_READ: begin
        res_slot = sel_q;
        if (any_q) begin
          res_status = ST_READ;
          res_slot   = SEL_W'(selidx_q);
          res_pid    = selkey_q[KEY_W-1:CALL_W];
          res_call   = selkey_q[CALL_W-1:0];
          res_acc    = selacc_q;
        end
      end
      OP_ENTER: begin
        if (pid0) begin
          res_status = ST_PID0;
        end else begin
          res_status = ST_STORED;
          res_pid    = pid_q;
        end
      end
      OP_EXIT: begin
        if (pid0) begin
          res_status = ST_PID0;
        end else begin
          res_pid  = pid_q;
          res_call = call_q;
          if (!svld_q) begin
            res_status = ST_NOSTART;
          end else begin
            res_delta = delta_q;
            if (stale_q) begin
              res_status = ST_STALE;
            end else if (any_q) begin
              res_status = ST_UPDATED;
              res_slot   = SEL_W'(selidx_q);
              res_acc    = upd_acc;
              acc_we     = 1'b1;
            end else if (full) begin
              res_status = ST_FULL;
            end else begin
              res_status    = ST_NEW;
              res_slot      = SEL_W'(used_q);
              acc_widx      = used_q[SLOT_W-1:0];
              wr_acc.total  = delta_q;
              wr_acc.count  = COUNT_W'(1);
              wr_acc.maxv   = d32;
              res_acc       = wr_acc;
              acc_we        = 1'b1;
              new_slot      = 1'b1;
            end
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  logic out_valid_q;
  assign out_free = !out_valid_q || out_if.ready;
  assign finish   = (state_q == S_DONE) && (!emit || out_free);

  // only a finishing step may write a cell or grow the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (finish && new_slot) begin
      used_q <= used_q + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_LOOK;
      S_LOOK:  state_d = S_SEL;
      S_SEL:   state_d = S_DONE;
      S_DONE:  if (finish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [STATUS_W-1:0] o_status_q;
  logic [SEL_W-1:0]    o_slot_q;
  logic [PID_BITS-1:0] o_pid_q;
  logic [CALL_W-1:0]   o_call_q;
  logic [TS_W-1:0]     o_delta_q;
  acc_t                o_acc_q;

  always_ff @(posedge clk_i) begin
    if (finish && emit) begin
      o_status_q <= res_status;
      o_slot_q   <= res_slot;
      o_pid_q    <= res_pid;
      o_call_q   <= res_call;
      o_delta_q  <= res_delta;
      o_acc_q    <= res_acc;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.status      = o_status_q;
  assign out_if.slot        = o_slot_q;
  assign out_if.key_pid     = o_pid_q;
  assign out_if.key_call    = o_call_q;
  assign out_if.delta_ns    = o_delta_q;
  assign out_if.sum_ns      = o_acc_q.total;
  assign out_if.event_count = o_acc_q.count;
  assign out_if.max_ns      = o_acc_q.maxv;

endmodule

// ===== bench/event_latency_accumulator_tb.sv =====
// self-checking bench of the event latency accumulator: directed, random and backpressure runs
module event_latency_accumulator_tb;
  import ela_pkg::*;

  localparam int unsigned PID_W     = PID_BITS_DEF;
  localparam int unsigned SLOTS     = ACC_ENTRIES_DEF;
  localparam int unsigned CYCLE_CAP = 600000;
  localparam int unsigned HOLD_LEN  = 400;
  localparam logic [APB_AW-1:0] ADDR_STALE_LIMIT = '0;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  // one result item as the block should present it
  typedef struct packed {
    status_e            status;
    logic [SEL_W-1:0]   slot;
    logic [PID_W-1:0]   key_pid;
    logic [CALL_W-1:0]  key_call;
    logic [TS_W-1:0]    delta;
    logic [TS_W-1:0]    total;
    logic [COUNT_W-1:0] count;
    logic [MAX_W-1:0]   maxv;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  ela_in_if  #(.PID_BITS(PID_W)) in_if ();
  ela_out_if #(.PID_BITS(PID_W)) out_if ();

  event_latency_accumulator #(.PID_BITS(PID_W), .ACC_ENTRIES(SLOTS)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the block state
  logic [TS_W-1:0]        start_time [2**PID_W];
  bit                     start_valid [2**PID_W];
  logic [PID_W+CALL_W-1:0] slot_key [SLOTS];
  logic [TS_W-1:0]        slot_total [SLOTS];
  logic [COUNT_W-1:0]     slot_count [SLOTS];
  logic [MAX_W-1:0]       slot_max [SLOTS];
  int unsigned            slots_used;
  logic [LIMIT_W-1:0]     stale_limit;

  result_t     awaited_results [$];
  result_t     got_want;
  int unsigned mismatches;
  int unsigned cycle_cnt;
  bit          calm;          // no random idling on either side
  bit          hold_req;      // asks the hold counter to start
  int unsigned hold_left;     // cycles the receiver still holds off
  logic [TS_W-1:0] now_ns;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run guard: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver hold-off, counted in its own process
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= HOLD_LEN;
      hold_req  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic flag_mismatch(input string what, input logic [TS_W-1:0] got,
                               input logic [TS_W-1:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_cnt);
    mismatches++;
  endtask

  // result side: check each accepted item, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("unexpected result, status", TS_W'(out_if.status), '0);
      end else begin
        got_want = awaited_results.pop_front();
        if (out_if.status !== got_want.status)
          flag_mismatch("status", TS_W'(out_if.status), TS_W'(got_want.status));
        if (out_if.slot !== got_want.slot)
          flag_mismatch("slot", TS_W'(out_if.slot), TS_W'(got_want.slot));
        if (out_if.key_pid !== got_want.key_pid)
          flag_mismatch("key_pid", TS_W'(out_if.key_pid), TS_W'(got_want.key_pid));
        if (out_if.key_call !== got_want.key_call)
          flag_mismatch("key_call", TS_W'(out_if.key_call), TS_W'(got_want.key_call));
        if (out_if.delta_ns !== got_want.delta)
          flag_mismatch("delta_ns", out_if.delta_ns, got_want.delta);
        if (out_if.sum_ns !== got_want.total)
          flag_mismatch("sum_ns", out_if.sum_ns, got_want.total);
        if (out_if.event_count !== got_want.count)
          flag_mismatch("event_count", TS_W'(out_if.event_count), TS_W'(got_want.count));
        if (out_if.max_ns !== got_want.maxv)
          flag_mismatch("max_ns", TS_W'(out_if.max_ns), TS_W'(got_want.maxv));
      end
    end
    if (!rst_ni || hold_left != 0) begin
      out_if.ready <= 1'b0;
    end else if (calm) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= 29);
    end
  end

  // predicts the result of one accepted item and updates the shadow state
  task automatic account_event(input op_e op, input logic [PID_W-1:0] pid,
                               input logic [CALL_W-1:0] call, input logic [TS_W-1:0] ts,
                               input logic [SEL_W-1:0] sel);
    result_t r;
    logic [TS_W-1:0] d;
    logic [MAX_W-1:0] d32;
    int s;
    int hit;
    r = '0;
    hit = -1;
    if (op == OP_NONE) return;
    if (op == OP_READ) begin
      r.slot = sel;
      if (sel < slots_used) begin
        r.status   = ST_READ;
        r.key_pid  = slot_key[sel][PID_W+CALL_W-1:CALL_W];
        r.key_call = slot_key[sel][CALL_W-1:0];
        r.total    = slot_total[sel];
        r.count    = slot_count[sel];
        r.maxv     = slot_max[sel];
      end else begin
        r.status = ST_EMPTY;
      end
      awaited_results.push_back(r);
      return;
    end
    if (pid == '0) begin
      r.status = ST_PID0;
      awaited_results.push_back(r);
      return;
    end
    r.key_pid = pid;
    if (op == OP_ENTER) begin
      start_time[pid]  = ts;
      start_valid[pid] = 1'b1;
      r.status = ST_STORED;
      awaited_results.push_back(r);
      return;
    end
    r.key_call = call;
    if (!start_valid[pid]) begin
      r.status = ST_NOSTART;
      awaited_results.push_back(r);
      return;
    end
    d = ts - start_time[pid];
    start_valid[pid] = 1'b0;
    r.delta = d;
    // stale compare against the zero-extended 40-bit limit
    if (d > {{(TS_W-LIMIT_W){1'b0}}, stale_limit}) begin
      r.status = ST_STALE;
      awaited_results.push_back(r);
      return;
    end
    d32 = (d > CLAMP32) ? CLAMP32[MAX_W-1:0] : d[MAX_W-1:0];
    for (s = 0; s < slots_used; s++) begin
      if (hit < 0 && slot_key[s] == {pid, call}) hit = s;
    end
    if (hit >= 0) begin
      slot_total[hit] += d;
      slot_count[hit] += 1;
      if (d32 > slot_max[hit]) slot_max[hit] = d32;
      r.status = ST_UPDATED;
    end else if (slots_used >= SLOTS) begin
      r.status = ST_FULL;
      awaited_results.push_back(r);
      return;
    end else begin
      hit = slots_used;
      slot_key[hit]   = {pid, call};
      slot_total[hit] = d;
      slot_count[hit] = 1;
      slot_max[hit]   = d32;
      slots_used++;
      r.status = ST_NEW;
    end
    r.slot  = hit[SEL_W-1:0];
    r.total = slot_total[hit];
    r.count = slot_count[hit];
    r.maxv  = slot_max[hit];
    awaited_results.push_back(r);
  endtask

  // offers one item, waits for the handshake, then records the prediction
  task automatic send_item(input op_e op, input logic [PID_W-1:0] pid,
                           input logic [CALL_W-1:0] call, input logic [TS_W-1:0] ts,
                           input logic [SEL_W-1:0] sel);
    @(posedge clk_i);
    while (!calm && $urandom_range(99) < 29) @(posedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.op           <= op;
    in_if.pid          <= pid;
    in_if.call_number  <= call;
    in_if.timestamp_ns <= ts;
    in_if.slot_select  <= sel;
    do @(posedge clk_i); while (!in_if.ready);
    in_if.valid <= 1'b0;
    account_event(op, pid, call, ts, sel);
  endtask

  // waits until every result is back, then lets an ignored item finish
  task automatic wait_drained();
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle, then read back the register
  task automatic write_stale_limit(input logic [LIMIT_W-1:0] value);
    wait_drained();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_STALE_LIMIT;
    pwdata  <= {{(APB_DW-LIMIT_W){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    stale_limit = value;
    @(posedge clk_i);
    if (pready !== 1'b1)
      flag_mismatch("pready", TS_W'(pready), TS_W'(1'b1));
    if (prdata !== {{(APB_DW-LIMIT_W){1'b0}}, value})
      flag_mismatch("stale limit readback", prdata, {{(APB_DW-LIMIT_W){1'b0}}, value});
  endtask

  // enter then exit on one pid with a chosen latency
  task automatic send_pair(input logic [PID_W-1:0] pid, input logic [CALL_W-1:0] call,
                           input logic [TS_W-1:0] t0, input logic [TS_W-1:0] t1);
    send_item(OP_ENTER, pid, CALL_W'($urandom_range(1023)), t0, SEL_W'($urandom_range(255)));
    send_item(OP_EXIT, pid, call, t1, SEL_W'($urandom_range(255)));
  endtask

  // pid zero, missing start, wrap, limit edges, reads, ignored op
  task automatic test_directed();
    send_item(OP_ENTER, '0, 10'd5, 64'd100, 8'd0);
    send_item(OP_EXIT, '0, 10'd5, 64'd200, 8'd0);
    send_item(OP_EXIT, '1, '1, '1, '1);
    send_item(OP_READ, '0, '0, '0, 8'd0);
    send_item(OP_NONE, 15'd7, 10'd3, 64'd9, 8'd1);
    // timestamp wraps between enter and exit
    send_pair('1, '1, 64'hFFFF_FFFF_FFFF_FFF0, 64'd5);
    // latency exactly at the limit is kept, one above is stale
    send_pair(15'd1, '0, '0, 64'd30000000000);
    send_pair(15'd1, '0, '0, 64'd30000000001);
    send_pair(15'd1, '0, 64'd10, 64'd15);
    send_item(OP_READ, '0, '0, '0, 8'd0);
    send_item(OP_READ, '0, '0, '0, 8'd1);
    send_item(OP_READ, '1, '1, '1, '1);
    send_pair(15'd2, 10'd512, '0, '1);
    // second enter overwrites the first start
    send_item(OP_ENTER, 15'd16384, 10'd1, 64'd1000, 8'd0);
    send_pair(15'd16384, 10'd1, 64'd2000, 64'd2500);
    send_item(OP_EXIT, 15'd16384, 10'd1, 64'd3000, 8'd0);
  endtask

  // limit at zero and at its maximum, clamp of the max field
  task automatic test_stale_limit();
    write_stale_limit('0);
    send_pair(15'd4, 10'd2, 64'd7, 64'd7);
    send_pair(15'd4, 10'd2, 64'd7, 64'd8);
    write_stale_limit(LIMIT_MAX);
    send_pair(15'd3, 10'd9, '0, {24'd0, LIMIT_MAX});
    send_pair(15'd3, 10'd9, '0, {24'd0, LIMIT_MAX} + 64'd1);
    send_pair(15'd3, 10'd9, 64'd5, 64'd6);
  endtask

  // mostly well-formed enter/exit traffic over a small key pool, plus noise
  task automatic test_random(input int unsigned n_items, input int unsigned step);
    logic [PID_W-1:0]  pid_pool [24];
    logic [CALL_W-1:0] call_pool [6];
    logic [PID_W-1:0]  p;
    logic [CALL_W-1:0] c;
    int unsigned i, pick;
    foreach (pid_pool[k]) pid_pool[k] = PID_W'($urandom_range(1, 2**PID_W - 1));
    foreach (call_pool[k]) call_pool[k] = CALL_W'($urandom_range(1023));
    pid_pool[0]  = '1;
    call_pool[0] = '1;
    call_pool[1] = '0;
    for (i = 0; i < n_items; i++) begin
      // a stretch without any idling in the middle
      calm = (i >= n_items / 3) && (i < n_items / 3 + 150);
      now_ns += TS_W'($urandom_range(0, step));
      if ($urandom_range(99) == 0) now_ns += 64'd2000000;
      p = pid_pool[$urandom_range(23)];
      c = call_pool[$urandom_range(5)];
      pick = $urandom_range(99);
      if (pick < 44) begin
        send_item(OP_ENTER, p, CALL_W'($urandom_range(1023)), now_ns,
                  SEL_W'($urandom_range(255)));
      end else if (pick < 88) begin
        send_item(OP_EXIT, p, c, now_ns, SEL_W'($urandom_range(255)));
      end else if (pick < 95) begin
        send_item(OP_READ, PID_W'($urandom_range(2**PID_W - 1)),
                  CALL_W'($urandom_range(1023)), now_ns, SEL_W'($urandom_range(255)));
      end else begin
        case ($urandom_range(2))
          0: send_item(OP_NONE, PID_W'($urandom_range(2**PID_W - 1)),
                       CALL_W'($urandom_range(1023)), {$urandom, $urandom},
                       SEL_W'($urandom_range(255)));
          1: send_item(op_e'($urandom_range(1)), '0, CALL_W'($urandom_range(1023)),
                       {$urandom, $urandom}, SEL_W'($urandom_range(255)));
          default: send_item(OP_EXIT, PID_W'($urandom_range(1, 2**PID_W - 1)),
                             CALL_W'($urandom_range(1023)), {$urandom, $urandom},
                             SEL_W'($urandom_range(255)));
        endcase
      end
    end
    calm = 1'b0;
  endtask

  // new keys until the table is full, a few more, then reads across it
  task automatic test_table_full();
    int unsigned i;
    while (slots_used < SLOTS) begin
      now_ns += 64'd100;
      send_pair(PID_W'($urandom_range(1, 2**PID_W - 1)), CALL_W'($urandom_range(1023)),
                now_ns, now_ns + TS_W'($urandom_range(0, 5000)));
    end
    for (i = 0; i < 6; i++) begin
      now_ns += 64'd100;
      send_pair(PID_W'($urandom_range(1, 2**PID_W - 1)), CALL_W'($urandom_range(1023)),
                now_ns, now_ns + TS_W'($urandom_range(0, 5000)));
    end
    // an existing key still accumulates once full
    send_pair(slot_key[0][PID_W+CALL_W-1:CALL_W], slot_key[0][CALL_W-1:0], now_ns,
              now_ns + 64'd77);
    for (i = 0; i < 20; i++) send_item(OP_READ, '0, '0, '0, SEL_W'($urandom_range(255)));
    send_item(OP_READ, '0, '0, '0, 8'd255);
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    int unsigned i;
    @(posedge clk_i);
    hold_req <= 1'b1;
    for (i = 0; i < 40; i++) begin
      now_ns += TS_W'($urandom_range(0, 3000));
      send_item(op_e'($urandom_range(2)), PID_W'($urandom_range(1, 2**PID_W - 1)),
                CALL_W'($urandom_range(1023)), now_ns, SEL_W'($urandom_range(255)));
    end
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_pause();
    int unsigned i;
    for (i = 0; i < 10; i++) send_item(OP_READ, '0, '0, '0, SEL_W'($urandom_range(255)));
    while (awaited_results.size() != 0) @(posedge clk_i);
    for (i = 0; i < 10; i++) send_item(OP_READ, '0, '0, '0, SEL_W'($urandom_range(255)));
  endtask

  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.op           = OP_ENTER;
    in_if.pid          = '0;
    in_if.call_number  = '0;
    in_if.timestamp_ns = '0;
    in_if.slot_select  = '0;
    out_if.ready       = 1'b0;
    calm               = 1'b0;
    hold_req           = 1'b0;
    hold_left          = 0;
    cycle_cnt          = 0;
    mismatches         = 0;
    slots_used         = 0;
    stale_limit        = STALE_RESET;
    foreach (start_valid[k]) start_valid[k] = 1'b0;
    now_ns = {$urandom, $urandom};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_stale_limit();
    write_stale_limit(40'd1000000);
    test_random(500, 20000);
    write_stale_limit(LIMIT_MAX);
    test_random(500, 20000);
    test_table_full();
    test_backpressure();
    test_pause();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== event_latency_accumulator.f =====
hdl/ela_pkg.sv
hdl/ela_if.sv
hdl/ela_smem.sv
hdl/ela_cell.sv
hdl/event_latency_accumulator.sv
bench/event_latency_accumulator_tb.sv
